// File: rtl/dfre_pkg.sv
// shared types, constants and tables of the frequency response evaluator
package dfre_pkg;

	localparam int MAX_TAPS     = 32;
	localparam int TAP_AW       = $clog2(MAX_TAPS);
	localparam int CNT_W        = 6;
	localparam int COEF_W       = 24;
	localparam int PHASE_BITS   = 16;
	localparam int ANG_W        = 32;
	localparam int CORDIC_ITERS = 30;
	localparam int TRIG_W       = 33;
	localparam int MUL_W        = 33;
	localparam int PROD_W       = 2 * MUL_W;
	localparam int ACC_W        = 61;
	localparam int RND_W        = 32;
	localparam int WIDE_W       = 60;
	localparam int QUO_W        = 32;
	localparam int FRAC_W       = 16;
	localparam int STEP_W       = 5;
	localparam int CFG_IDX_W    = 2;
	localparam int OUT_W        = 32;

	localparam logic signed [TRIG_W-1:0] CORDIC_X0 = 33'sd652032874;
	localparam logic signed [ACC_W-1:0]  RND_HALF  = {{(ACC_W-30){1'b0}}, 1'b1, 29'b0};
	localparam logic [OUT_W-1:0]         POS_LIM   = 32'h7FFF_FFFF;
	localparam logic [OUT_W-1:0]         NEG_LIM   = 32'h8000_0000;

	typedef enum logic [1:0] {
		OP_LOAD_B = 2'd0,
		OP_LOAD_A = 2'd1,
		OP_EVAL   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_DEN_ZERO  = 2'd1,
		ST_RESP_ZERO = 2'd2,
		ST_SAT       = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NUM_COUNT = 2'd0,
		REG_DEN_COUNT = 2'd1,
		REG_SPARE2    = 2'd2,
		REG_SPARE3    = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_TAP_RD,
		S_CORDIC,
		S_MAC,
		S_ROUND,
		S_PROD,
		S_DIV_INIT,
		S_DIV,
		S_DIV_END,
		S_RESP
	} state_t;

	// cordic arctangent steps, 2^32 per turn
	function automatic logic [31:0] atan_lut(input logic [STEP_W-1:0] i);
		logic [31:0] v;
		case (i)
			5'd0:  v = 32'h20000000;
			5'd1:  v = 32'h12E4051E;
			5'd2:  v = 32'h09FB385B;
			5'd3:  v = 32'h051111D4;
			5'd4:  v = 32'h028B0D43;
			5'd5:  v = 32'h0145D7E1;
			5'd6:  v = 32'h00A2F61E;
			5'd7:  v = 32'h00517C55;
			5'd8:  v = 32'h0028BE53;
			5'd9:  v = 32'h00145F2F;
			5'd10: v = 32'h000A2F98;
			5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6;
			5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2FA;
			5'd15: v = 32'h0000517D;
			5'd16: v = 32'h000028BE;
			5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A30;
			5'd19: v = 32'h00000518;
			5'd20: v = 32'h0000028C;
			5'd21: v = 32'h00000146;
			5'd22: v = 32'h000000A3;
			5'd23: v = 32'h00000051;
			5'd24: v = 32'h00000029;
			5'd25: v = 32'h00000014;
			5'd26: v = 32'h0000000A;
			5'd27: v = 32'h00000005;
			5'd28: v = 32'h00000003;
			5'd29: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage

// File: rtl/dfre_ram.sv
// generic single-write, single-read ram with registered read data
module dfre_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/digital_freq_response_eval.sv
// frequency response evaluator: coefficient stores, cordic, complex mac and divider
//
// usage
//   item channel: an item is taken when start is high and busy is low.
//   operation 0 / 1 writes coef_value into numerator / denominator tap coef_index;
//   operation 2 evaluates H = B/A at angle phase*pi/32768; operation 3 does nothing.
//   every item gives one result: done pulses for one cycle with resp_real,
//   resp_imag (Q16.16) and status. the receiver cannot stall, so done flags the
//   result for that one cycle only and busy drops in the cycle after.
//   config channel: cfg_ready is always high; cfg_index 0 sets numerator_count,
//   1 sets denominator_count, other indexes are ignored. write only while idle.
// sequence
//   loads, unused codes and an empty denominator count: done comes in the cycle
//   right after the item is taken.
//   evaluate: each tap is one ram read, 30 cordic iterations of a single rotator
//   and a mac phase with 4 passes through the one shared multiplier; then a
//   rounding step, 6 multiplier passes for |A|^2 and B*conj(A), two divisions
//   (32 restoring steps each, skipped when the quotient saturates) and the
//   result cycle. an all-zero denominator or a zero A skips the products and
//   divisions. the block takes one item at a time.
// reset
//   both coefficient stores read as zero (per-tap valid bits clear at once),
//   both counts return to 1, no clearing pass is needed.
module digital_freq_response_eval
	import dfre_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  operation,
	input  logic [4:0]                  coef_index,
	input  logic signed [COEF_W-1:0]    coef_value,
	input  logic [15:0]                 phase,
	output logic                        done,
	output logic signed [OUT_W-1:0]     resp_real,
	output logic signed [OUT_W-1:0]     resp_imag,
	output logic [1:0]                  status,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CNT_W-1:0]            cfg_data
);

	state_t state_q, state_d;

	// configuration
	logic [CNT_W-1:0] nb_q, na_q, nb_eff, na_eff;

	// coefficient stores with per-tap valid bits
	logic [MAX_TAPS-1:0] num_vld_q, den_vld_q;
	logic                num_we, den_we, ram_re;
	logic [COEF_W-1:0]   num_rdata, den_rdata;
	logic                item_take, idx_ok;

	// tap loop
	logic [CNT_W-1:0]      k_q, kmax_q;
	logic [PHASE_BITS-1:0] ph_q, ang_q;
	logic [STEP_W-1:0]     step_q;
	logic                  allzero_q;

	// cordic rotator
	logic signed [TRIG_W-1:0] x_q, y_q, z_q;
	logic [1:0]               quad_q;
	logic signed [TRIG_W-1:0] cos_v, sin_v, xs, ys, at;
	logic [ANG_W-1:0]         ang32, ang_off, ru;
	logic [1:0]               quad_v;

	// shared multiplier
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [COEF_W-1:0] b_coef, a_coef;

	// accumulators and rounded sums
	logic signed [ACC_W-1:0] acc_br_q, acc_bi_q, acc_ar_q, acc_ai_q;
	logic signed [RND_W-1:0] br_q, bi_q, ar_q, ai_q;
	logic signed [RND_W-1:0] br_r, bi_r, ar_r, ai_r;

	// division
	logic [WIDE_W-1:0]        den_q;
	logic signed [WIDE_W-1:0] nr_q, ni_q, n_sel;
	logic [WIDE_W-1:0]        n_mag;
	logic [ACC_W-1:0]         rem_q, trial;
	logic [QUO_W-1:0]         dvd_q, quo_q, m_v, lim_v, val_v;
	logic                     neg_q, dsel_q, sat_q, dsat_q, sat_now;

	// result
	logic signed [OUT_W-1:0] res_real_q, res_imag_q;
	status_t                 status_q;

	function automatic logic signed [RND_W-1:0] rnd(input logic signed [ACC_W-1:0] a);
		logic signed [ACC_W-1:0] t;
		t = a + RND_HALF;
		return RND_W'(t >>> 30);
	endfunction

	assign item_take = start && !busy;
	assign idx_ok    = 32'(coef_index) < MAX_TAPS;
	assign nb_eff    = (32'(nb_q) > MAX_TAPS) ? CNT_W'(MAX_TAPS) : nb_q;
	assign na_eff    = (32'(na_q) > MAX_TAPS) ? CNT_W'(MAX_TAPS) : na_q;

	// ---------------------------------------------------------------- stores
	dfre_ram #(.WIDTH(COEF_W), .DEPTH(MAX_TAPS)) u_num_ram (
		.clk   (clk),
		.we    (num_we),
		.waddr (coef_index[TAP_AW-1:0]),
		.wdata (coef_value),
		.re    (ram_re),
		.raddr (k_q[TAP_AW-1:0]),
		.rdata (num_rdata)
	);

	dfre_ram #(.WIDTH(COEF_W), .DEPTH(MAX_TAPS)) u_den_ram (
		.clk   (clk),
		.we    (den_we),
		.waddr (coef_index[TAP_AW-1:0]),
		.wdata (coef_value),
		.re    (ram_re),
		.raddr (k_q[TAP_AW-1:0]),
		.rdata (den_rdata)
	);

	// taps past the count or never written count as zero
	assign b_coef = (k_q < nb_eff && num_vld_q[k_q[TAP_AW-1:0]]) ? num_rdata : '0;
	assign a_coef = (k_q < na_eff && den_vld_q[k_q[TAP_AW-1:0]]) ? den_rdata : '0;

	// ---------------------------------------------------------------- cordic
	// quadrant split of the tap angle, residue in [-45,45) degrees
	assign ang32   = {ang_q, {(ANG_W-PHASE_BITS){1'b0}}};
	assign ang_off = ang32 + 32'h2000_0000;
	assign quad_v  = ang_off[ANG_W-1:ANG_W-2];
	assign ru      = ang32 - {quad_v, {(ANG_W-2){1'b0}}};

	assign xs = x_q >>> step_q;
	assign ys = y_q >>> step_q;
	assign at = TRIG_W'(signed'({1'b0, atan_lut(step_q)}));

	always_comb begin
		case (quad_q)
			2'd0: begin
				cos_v = x_q;
				sin_v = y_q;
			end
			2'd1: begin
				cos_v = -y_q;
				sin_v = x_q;
			end
			2'd2: begin
				cos_v = -x_q;
				sin_v = -y_q;
			end
			default: begin
				cos_v = y_q;
				sin_v = -x_q;
			end
		endcase
	end

	// ------------------------------------------------------ multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_MAC: begin
				case (step_q)
					5'd0: begin
						mul_a = MUL_W'(b_coef);
						mul_b = cos_v;
					end
					5'd1: begin
						mul_a = MUL_W'(b_coef);
						mul_b = sin_v;
					end
					5'd2: begin
						mul_a = MUL_W'(a_coef);
						mul_b = cos_v;
					end
					5'd3: begin
						mul_a = MUL_W'(a_coef);
						mul_b = sin_v;
					end
					default: ;
				endcase
			end
			S_PROD: begin
				case (step_q)
					5'd0: begin
						mul_a = MUL_W'(ar_q);
						mul_b = MUL_W'(ar_q);
					end
					5'd1: begin
						mul_a = MUL_W'(ai_q);
						mul_b = MUL_W'(ai_q);
					end
					5'd2: begin
						mul_a = MUL_W'(br_q);
						mul_b = MUL_W'(ar_q);
					end
					5'd3: begin
						mul_a = MUL_W'(bi_q);
						mul_b = MUL_W'(ai_q);
					end
					5'd4: begin
						mul_a = MUL_W'(bi_q);
						mul_b = MUL_W'(ar_q);
					end
					5'd5: begin
						mul_a = MUL_W'(ai_q);
						mul_b = MUL_W'(br_q);
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// ---------------------------------------------------------------- division
	assign br_r  = rnd(acc_br_q);
	assign bi_r  = rnd(acc_bi_q);
	assign ar_r  = rnd(acc_ar_q);
	assign ai_r  = rnd(acc_ai_q);

	assign n_sel = dsel_q ? ni_q : nr_q;
	assign n_mag = n_sel[WIDE_W-1] ? WIDE_W'(-n_sel) : WIDE_W'(n_sel);
	assign trial = {rem_q[ACC_W-2:0], dvd_q[QUO_W-1]};

	// quotient magnitude, clamped to the signed Q16.16 range
	assign lim_v   = neg_q ? NEG_LIM : POS_LIM;
	assign sat_now = dsat_q || (quo_q > lim_v);
	assign m_v     = sat_now ? lim_v : quo_q;
	assign val_v   = neg_q ? (QUO_W'(0) - m_v) : m_v;

	// -------------------------------------------------------------- next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (operation == OP_EVAL && na_eff != '0) begin
						state_d = S_TAP_RD;
					end else begin
						state_d = S_RESP;
					end
				end
			end
			S_TAP_RD: state_d = S_CORDIC;
			S_CORDIC: begin
				if (32'(step_q) == CORDIC_ITERS - 1) begin
					state_d = S_MAC;
				end
			end
			S_MAC: begin
				if (step_q == 5'd4) begin
					state_d = (k_q + 1'b1 == kmax_q) ? S_ROUND : S_TAP_RD;
				end
			end
			S_ROUND: begin
				if (allzero_q || (ar_r == '0 && ai_r == '0)) begin
					state_d = S_RESP;
				end else begin
					state_d = S_PROD;
				end
			end
			S_PROD: begin
				if (step_q == 5'd6) begin
					state_d = S_DIV_INIT;
				end
			end
			S_DIV_INIT: begin
				if ({{FRAC_W{1'b0}}, n_mag} >= {den_q, {FRAC_W{1'b0}}}) begin
					state_d = S_DIV_END;
				end else begin
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				if (32'(step_q) == QUO_W - 1) begin
					state_d = S_DIV_END;
				end
			end
			S_DIV_END: state_d = dsel_q ? S_RESP : S_DIV_INIT;
			S_RESP:    state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// ------------------------------------------------------------------ outputs
	always_comb begin
		busy   = (state_q != S_IDLE);
		done   = (state_q == S_RESP);
		ram_re = (state_q == S_TAP_RD);
		num_we = item_take && operation == OP_LOAD_B && idx_ok;
		den_we = item_take && operation == OP_LOAD_A && idx_ok;
	end

	assign cfg_ready = 1'b1;
	assign resp_real = res_real_q;
	assign resp_imag = res_imag_q;
	assign status    = status_q;

	// ------------------------------------------------------------ control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			nb_q      <= CNT_W'(1);
			na_q      <= CNT_W'(1);
			num_vld_q <= '0;
			den_vld_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_NUM_COUNT: nb_q <= cfg_data;
					REG_DEN_COUNT: na_q <= cfg_data;
					default: ;
				endcase
			end
			if (num_we) begin
				num_vld_q[coef_index[TAP_AW-1:0]] <= 1'b1;
			end
			if (den_we) begin
				den_vld_q[coef_index[TAP_AW-1:0]] <= 1'b1;
			end
		end
	end

	// ----------------------------------------------------------------- datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				// loads and unused codes answer zeros, an empty denominator flags
				res_real_q <= '0;
				res_imag_q <= '0;
				status_q   <= (operation == OP_EVAL) ? ST_DEN_ZERO : ST_OK;
				k_q        <= '0;
				kmax_q     <= (nb_eff > na_eff) ? nb_eff : na_eff;
				ph_q       <= phase[PHASE_BITS-1:0];
				ang_q      <= '0;
				allzero_q  <= 1'b1;
				acc_br_q   <= '0;
				acc_bi_q   <= '0;
				acc_ar_q   <= '0;
				acc_ai_q   <= '0;
				step_q     <= '0;
			end
			S_TAP_RD: begin
				x_q    <= CORDIC_X0;
				y_q    <= '0;
				z_q    <= TRIG_W'(signed'(ru));
				quad_q <= quad_v;
				ang_q  <= ang_q + ph_q;
				step_q <= '0;
			end
			S_CORDIC: begin
				if (!z_q[TRIG_W-1]) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - at;
				end else begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + at;
				end
				step_q <= (32'(step_q) == CORDIC_ITERS - 1) ? '0 : step_q + 1'b1;
			end
			S_MAC: begin
				// product of the previous step lands here
				case (step_q)
					5'd0: begin
						if (a_coef != '0) begin
							allzero_q <= 1'b0;
						end
					end
					5'd1: acc_br_q <= acc_br_q + prod_q[ACC_W-1:0];
					5'd2: acc_bi_q <= acc_bi_q - prod_q[ACC_W-1:0];
					5'd3: acc_ar_q <= acc_ar_q + prod_q[ACC_W-1:0];
					5'd4: acc_ai_q <= acc_ai_q - prod_q[ACC_W-1:0];
					default: ;
				endcase
				if (step_q == 5'd4) begin
					step_q <= '0;
					k_q    <= k_q + 1'b1;
				end else begin
					step_q <= step_q + 1'b1;
				end
			end
			S_ROUND: begin
				br_q   <= br_r;
				bi_q   <= bi_r;
				ar_q   <= ar_r;
				ai_q   <= ai_r;
				step_q <= '0;
				if (allzero_q) begin
					status_q <= ST_DEN_ZERO;
				end else begin
					status_q <= ST_RESP_ZERO;
				end
			end
			S_PROD: begin
				case (step_q)
					5'd1: den_q <= prod_q[WIDE_W-1:0];
					5'd2: den_q <= den_q + prod_q[WIDE_W-1:0];
					5'd3: nr_q  <= prod_q[WIDE_W-1:0];
					5'd4: nr_q  <= nr_q + prod_q[WIDE_W-1:0];
					5'd5: ni_q  <= prod_q[WIDE_W-1:0];
					5'd6: ni_q  <= ni_q - prod_q[WIDE_W-1:0];
					default: ;
				endcase
				step_q <= (step_q == 5'd6) ? '0 : step_q + 1'b1;
				dsel_q <= 1'b0;
				sat_q  <= 1'b0;
			end
			S_DIV_INIT: begin
				// quotient of at least 2^32 in Q16.16 saturates without dividing
				neg_q  <= n_sel[WIDE_W-1];
				dsat_q <= {{FRAC_W{1'b0}}, n_mag} >= {den_q, {FRAC_W{1'b0}}};
				rem_q  <= ACC_W'(n_mag >> FRAC_W);
				dvd_q  <= {n_mag[FRAC_W-1:0], {(QUO_W-FRAC_W){1'b0}}};
				quo_q  <= '0;
				step_q <= '0;
			end
			S_DIV: begin
				if (trial >= ACC_W'(den_q)) begin
					rem_q <= trial - ACC_W'(den_q);
					quo_q <= {quo_q[QUO_W-2:0], 1'b1};
				end else begin
					rem_q <= trial;
					quo_q <= {quo_q[QUO_W-2:0], 1'b0};
				end
				dvd_q  <= {dvd_q[QUO_W-2:0], 1'b0};
				step_q <= step_q + 1'b1;
			end
			S_DIV_END: begin
				if (dsel_q) begin
					res_imag_q <= val_v;
					status_q   <= (sat_q || sat_now) ? ST_SAT : ST_OK;
				end else begin
					res_real_q <= val_v;
				end
				sat_q  <= sat_q || sat_now;
				dsel_q <= 1'b1;
			end
			default: ;
		endcase
	end

endmodule

// File: rtl/dfre_checker.sv
// port-level checks of the frequency response evaluator, bound to the top level
module dfre_checker
	import dfre_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    start,
	input logic                    busy,
	input logic                    done,
	input logic signed [OUT_W-1:0] resp_real,
	input logic signed [OUT_W-1:0] resp_imag,
	input logic [1:0]              status
);

	// a result only appears while an item is in flight
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result strobe while idle");

	// a taken item keeps the block busy
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("item taken but block not busy");

	// a result is not repeated, block is free right after
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (!busy && !done)) else $error("block still busy after result");

	// flagged denominator cases answer zeros
	a_zero_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == ST_DEN_ZERO || status == ST_RESP_ZERO))
		|-> (resp_real == '0 && resp_imag == '0))
		else $error("nonzero response with zero denominator status");

endmodule

bind digital_freq_response_eval dfre_checker u_dfre_checker (.*);
